// ===== rtl/gfp_pkg.sv =====
// Shared types and constants for the frame parser.
// Used by gfp_frame_fsm, gfp_field_store and greis_frame_parser_top.
package gfp_pkg;

  localparam int LenW        = 12;  // body length field and byte counter
  localparam int DecodeBytes = 37;  // body bytes that any decoded field reaches
  localparam int CfgIdxW     = 1;

  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] IdCharLow = 8'h30;
  localparam logic [7:0] IdCharHigh = 8'h7E;

  localparam logic [LenW-1:0] MaxLenReset = 12'd256;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_FRAME_LENGTH = 1'b0,
    REG_DROP_NEWLINE     = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_SYNC   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_DECODED     = 3'd0,
    ST_UNKNOWN_ID  = 3'd1,
    ST_SHORT_BODY  = 3'd2,
    ST_BAD_SUM     = 3'd3,
    ST_BAD_LENGTH  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    KIND_RX_TIME  = 3'd0,
    KIND_SOL_TIME = 3'd1,
    KIND_POSITION = 3'd2,
    KIND_VELOCITY = 3'd3,
    KIND_RMS      = 3'd4,
    KIND_OTHER    = 3'd5
  } kind_t;

  // Per-byte outcome of the frame state machine.
  typedef struct packed {
    logic            emit;
    status_t         status;      // decoded, bad checksum or bad length only
    logic            store_en;
    logic [LenW-1:0] store_idx;
    logic [7:0]      data;
    logic [LenW-1:0] frame_length;
    logic [7:0]      id_first;
    logic [7:0]      id_second;
  } fsm_event_t;

  typedef struct packed {
    status_t     status;
    kind_t       kind;
    logic [7:0]  id_first;
    logic [7:0]  id_second;
    logic [31:0] time_ms;
    logic [7:0]  solution_kind;
    logic [63:0] word_a;
    logic [63:0] word_b;
    logic [63:0] word_c;
    logic [31:0] word_d;
  } result_t;

endpackage

// ===== rtl/greis_frame_parser_top.sv =====
// A byte accepted into the input register is processed from there, and any result it
// causes is loaded into the result register when the output side can advance.
// Throughput: one byte per cycle; the input register and the result register are
// both loaded in the same cycle, so a waiting result stalls input only when it is not taken.
// Reset (rst, synchronous): parser in ID search, checksum and counters cleared,
// max_frame_length 256, drop_newline_in_body 1; the body byte store is not cleared.
module greis_frame_parser_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [2:0]                    kind,
  output logic [7:0]                    id_first,
  output logic [7:0]                    id_second,
  output logic [31:0]                   time_ms,
  output logic [7:0]                    solution_kind,
  output logic [63:0]                   word_a,
  output logic [63:0]                   word_b,
  output logic [63:0]                   word_c,
  output logic [31:0]                   word_d,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gfp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [gfp_pkg::LenW-1:0]      cfg_data
);

  logic                     byte_valid;
  logic [7:0]               byte_hold;
  logic                     advance;
  logic [gfp_pkg::LenW-1:0] max_frame_length;
  logic                     drop_newline;
  gfp_pkg::fsm_event_t      ev;
  gfp_pkg::result_t         res;
  gfp_pkg::result_t         res_hold;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= gfp_pkg::MaxLenReset;
      drop_newline     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (gfp_pkg::cfg_reg_t'(cfg_index))
        gfp_pkg::REG_MAX_FRAME_LENGTH: max_frame_length <= cfg_data;
        gfp_pkg::REG_DROP_NEWLINE:     drop_newline     <= cfg_data[0];
        default:                       drop_newline     <= drop_newline;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_hold <= rx_byte;
    end
  end

  gfp_frame_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .proc    (byte_valid && advance),
    .rx      (byte_hold),
    .max_len (max_frame_length),
    .drop_nl (drop_newline),
    .ev      (ev)
  );

  gfp_field_store u_store (
    .clk (clk),
    .ev  (ev),
    .res (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= ev.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.emit) begin
      res_hold <= res;
    end
  end

  assign status        = res_hold.status;
  assign kind          = res_hold.kind;
  assign id_first      = res_hold.id_first;
  assign id_second     = res_hold.id_second;
  assign time_ms       = res_hold.time_ms;
  assign solution_kind = res_hold.solution_kind;
  assign word_a        = res_hold.word_a;
  assign word_b        = res_hold.word_b;
  assign word_c        = res_hold.word_c;
  assign word_d        = res_hold.word_d;

endmodule

// ===== rtl/gfp_frame_fsm.sv =====
// Frame state machine: ID search, hex length, body count and running checksum.
// Depends on gfp_pkg.
module gfp_frame_fsm (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     proc,
  input  logic [7:0]               rx,
  input  logic [gfp_pkg::LenW-1:0] max_len,
  input  logic                     drop_nl,
  output gfp_pkg::fsm_event_t      ev
);

  gfp_pkg::phase_t           phase, phase_next;
  logic                      have_first, have_first_next;
  logic [7:0]                first_char, first_char_next;
  logic [7:0]                second_char, second_char_next;
  logic [1:0]                hex_digits, hex_digits_next;
  logic [gfp_pkg::LenW-1:0]  frame_length, frame_length_next;
  logic [gfp_pkg::LenW-1:0]  bytes_seen, bytes_seen_next;
  logic [7:0]                running_sum, running_sum_next;

  logic                      newline;
  logic                      id_char;
  logic                      hex_ok;
  logic [3:0]                hex_val;
  logic [7:0]                sum_rot;
  logic [gfp_pkg::LenW-1:0]  bytes_inc;
  logic [gfp_pkg::LenW-1:0]  len_shift;

  function automatic logic [7:0] rotl2(input logic [7:0] v);
    rotl2 = {v[5:0], v[7:6]};
  endfunction

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (rx >= 8'h30 && rx <= 8'h39) begin
      hex_val = rx[3:0];
    end else if ((rx >= 8'h41 && rx <= 8'h46) || (rx >= 8'h61 && rx <= 8'h66)) begin
      hex_val = rx[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign newline   = (rx == gfp_pkg::CharLf) || (rx == gfp_pkg::CharCr);
  assign id_char   = (rx >= gfp_pkg::IdCharLow) && (rx <= gfp_pkg::IdCharHigh);
  assign sum_rot   = rotl2(running_sum);
  assign bytes_inc = bytes_seen + 1'b1;
  assign len_shift = {frame_length[gfp_pkg::LenW-5:0], hex_val};

  always_comb begin
    phase_next        = phase;
    have_first_next   = have_first;
    first_char_next   = first_char;
    second_char_next  = second_char;
    hex_digits_next   = hex_digits;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    running_sum_next  = running_sum;

    ev              = '0;
    ev.status       = gfp_pkg::ST_DECODED;
    ev.data         = rx;
    ev.store_idx    = bytes_seen;
    ev.frame_length = frame_length;
    ev.id_first     = first_char;
    ev.id_second    = second_char;

    if (proc) begin
      case (phase)
        gfp_pkg::PH_BODY: begin
          if (!(newline && drop_nl)) begin
            ev.store_en     = 1'b1;
            bytes_seen_next = bytes_inc;
            if (bytes_inc == frame_length) begin
              // last body byte is the checksum
              ev.emit         = 1'b1;
              ev.status       = (sum_rot == rx) ? gfp_pkg::ST_DECODED : gfp_pkg::ST_BAD_SUM;
              phase_next      = gfp_pkg::PH_SYNC;
              have_first_next = 1'b0;
            end else begin
              running_sum_next = sum_rot ^ rx;
            end
          end
        end
        gfp_pkg::PH_LENGTH: begin
          if (!newline) begin
            if (!hex_ok) begin
              phase_next      = gfp_pkg::PH_SYNC;
              have_first_next = 1'b0;
            end else begin
              frame_length_next = len_shift;
              running_sum_next  = sum_rot ^ rx;
              hex_digits_next   = hex_digits + 2'd1;
              if (hex_digits == 2'd2) begin
                hex_digits_next = 2'd0;
                bytes_seen_next = '0;
                if (len_shift != '0 && len_shift <= max_len) begin
                  phase_next = gfp_pkg::PH_BODY;
                end else begin
                  phase_next      = gfp_pkg::PH_SYNC;
                  have_first_next = 1'b0;
                  ev.emit         = 1'b1;
                  ev.status       = gfp_pkg::ST_BAD_LENGTH;
                end
              end
            end
          end
        end
        default: begin
          if (!newline) begin
            phase_next = gfp_pkg::PH_SYNC;
            if (id_char) begin
              if (!have_first) begin
                first_char_next = rx;
                have_first_next = 1'b1;
              end else begin
                second_char_next  = rx;
                have_first_next   = 1'b0;
                hex_digits_next   = 2'd0;
                frame_length_next = '0;
                running_sum_next  = rotl2(first_char) ^ rx;
                phase_next        = gfp_pkg::PH_LENGTH;
              end
            end else begin
              have_first_next = 1'b0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= gfp_pkg::PH_SYNC;
      have_first   <= 1'b0;
      first_char   <= '0;
      second_char  <= '0;
      hex_digits   <= '0;
      frame_length <= '0;
      bytes_seen   <= '0;
      running_sum  <= '0;
    end else begin
      phase        <= phase_next;
      have_first   <= have_first_next;
      first_char   <= first_char_next;
      second_char  <= second_char_next;
      hex_digits   <= hex_digits_next;
      frame_length <= frame_length_next;
      bytes_seen   <= bytes_seen_next;
      running_sum  <= running_sum_next;
    end
  end

  // A body always has a nonzero length and the count never reaches it
  a_body_count: assert property (@(posedge clk) disable iff (rst)
    phase == gfp_pkg::PH_BODY |-> frame_length != '0 && bytes_seen < frame_length)
    else $error("body counter out of range");

  a_emit_resync: assert property (@(posedge clk) disable iff (rst)
    ev.emit |=> phase == gfp_pkg::PH_SYNC && !have_first)
    else $error("parser did not resync after a result");

  a_digits: assert property (@(posedge clk) disable iff (rst)
    hex_digits != 2'd3 && (phase != gfp_pkg::PH_SYNC || hex_digits == 2'd0 ||
    hex_digits == 2'd1 || hex_digits == 2'd2))
    else $error("hex digit count overflow");

  a_length_no_first: assert property (@(posedge clk) disable iff (rst)
    phase == gfp_pkg::PH_LENGTH |-> !have_first)
    else $error("first ID byte held during length");

endmodule

// ===== rtl/gfp_field_store.sv =====
// Keeps the leading body bytes of the current frame and decodes the result fields.
// Depends on gfp_pkg.
module gfp_field_store (
  input  logic                clk,
  input  gfp_pkg::fsm_event_t ev,
  output gfp_pkg::result_t    res
);

  logic [7:0]       fb [gfp_pkg::DecodeBytes];
  gfp_pkg::kind_t   kind;
  logic [gfp_pkg::LenW-1:0] need;
  gfp_pkg::status_t status;

  always_ff @(posedge clk) begin
    for (int i = 0; i < gfp_pkg::DecodeBytes; i++) begin
      if (ev.store_en && ev.store_idx == gfp_pkg::LenW'(i)) begin
        fb[i] <= ev.data;
      end
    end
  end

  always_comb begin
    if (ev.id_first == 8'h7E && ev.id_second == 8'h7E) begin
      kind = gfp_pkg::KIND_RX_TIME;
    end else if (ev.id_first == "S" && ev.id_second == "T") begin
      kind = gfp_pkg::KIND_SOL_TIME;
    end else if (ev.id_first == "m" && ev.id_second == "p") begin
      kind = gfp_pkg::KIND_POSITION;
    end else if (ev.id_first == "V" && ev.id_second == "E") begin
      kind = gfp_pkg::KIND_VELOCITY;
    end else if (ev.id_first == "S" && ev.id_second == "G") begin
      kind = gfp_pkg::KIND_RMS;
    end else begin
      kind = gfp_pkg::KIND_OTHER;
    end
  end

  always_comb begin
    case (kind)
      gfp_pkg::KIND_RX_TIME:  need = 12'd5;
      gfp_pkg::KIND_SOL_TIME: need = 12'd6;
      gfp_pkg::KIND_POSITION: need = 12'd45;
      default:                need = 12'd18;
    endcase
  end

  always_comb begin
    status = ev.status;
    if (ev.status == gfp_pkg::ST_DECODED) begin
      if (kind == gfp_pkg::KIND_OTHER) begin
        status = gfp_pkg::ST_UNKNOWN_ID;
      end else if (ev.frame_length < need) begin
        status = gfp_pkg::ST_SHORT_BODY;
      end
    end
  end

  // Fields are little-endian; anything the ID does not use stays zero
  always_comb begin
    res           = '0;
    res.status    = status;
    res.kind      = kind;
    res.id_first  = ev.id_first;
    res.id_second = ev.id_second;
    if (status == gfp_pkg::ST_DECODED) begin
      case (kind)
        gfp_pkg::KIND_RX_TIME: begin
          res.time_ms = {fb[3], fb[2], fb[1], fb[0]};
        end
        gfp_pkg::KIND_SOL_TIME: begin
          res.time_ms       = {fb[3], fb[2], fb[1], fb[0]};
          res.solution_kind = fb[4];
        end
        gfp_pkg::KIND_POSITION: begin
          for (int k = 0; k < 8; k++) begin
            res.word_a[8*k +: 8] = fb[k];
            res.word_b[8*k +: 8] = fb[8 + k];
            res.word_c[8*k +: 8] = fb[16 + k];
          end
          res.word_d        = {fb[35], fb[34], fb[33], fb[32]};
          res.solution_kind = fb[36];
        end
        gfp_pkg::KIND_VELOCITY, gfp_pkg::KIND_RMS: begin
          res.word_a        = {32'd0, fb[3], fb[2], fb[1], fb[0]};
          res.word_b        = {32'd0, fb[7], fb[6], fb[5], fb[4]};
          res.word_c        = {32'd0, fb[11], fb[10], fb[9], fb[8]};
          res.word_d        = {fb[15], fb[14], fb[13], fb[12]};
          res.solution_kind = fb[16];
        end
        default: begin
          res.time_ms = '0;
        end
      endcase
    end
  end

endmodule
